// ===== rtl/rapqt_pkg.sv =====
`default_nettype none
package rapqt_pkg;

  // Fixed field widths of the request, response and configuration beats.
  localparam int TYPE_W    = 2;
  localparam int INDEX_W   = 10;
  localparam int OPERAND_W = 32;
  localparam int RESULT_W  = 32;
  localparam int SIZE_W    = 11;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  typedef enum logic [TYPE_W-1:0] {
    REQ_LOAD  = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_QUERY = 2'd2
  } req_type_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_QTAIL,
    ST_QOUT,
    ST_AVISIT,
    ST_AUPD
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/rapqt_req_if.sv =====
`default_nettype none
interface rapqt_req_if;
  logic                               valid;
  logic                               ready;
  logic [rapqt_pkg::TYPE_W-1:0]       req_type;
  logic [rapqt_pkg::INDEX_W-1:0]      first_index;
  logic [rapqt_pkg::INDEX_W-1:0]      last_index;
  logic signed [rapqt_pkg::OPERAND_W-1:0] operand_value;

  modport source (output valid, req_type, first_index, last_index, operand_value,
                  input ready);
  modport sink   (input valid, req_type, first_index, last_index, operand_value,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/rapqt_rsp_if.sv =====
`default_nettype none
interface rapqt_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [rapqt_pkg::RESULT_W-1:0] point_value;
  logic                                  index_error;

  modport source (output valid, point_value, index_error, input ready);
  modport sink   (input valid, point_value, index_error, output ready);
endinterface
`default_nettype wire

// ===== rtl/rapqt_cfg_if.sv =====
`default_nettype none
interface rapqt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rapqt_pkg::SIZE_W-1:0]   size_in_use;

  modport source (output valid, size_in_use, input ready);
  modport sink   (input valid, size_in_use, output ready);
endinterface
`default_nettype wire

// ===== rtl/rapqt_node_ram.sv =====
`default_nettype none
module rapqt_node_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/range_add_point_query_tree.sv =====
`default_nettype none
// Channel   Modport  Beat contents
// --------  -------  -------------------------------------------------------
// req       sink     req_type, first_index, last_index, operand_value
// rsp       source   point_value, index_error (one beat per point query)
// cfg       sink     size_in_use (always ready)
//
// After reset a clearing pass writes zero to every node, one node per cycle, and req
// is not ready until that pass has finished. A load or a query walks from the root
// to its leaf, one tree level per cycle through the node memory; a load writes the
// leaf and a query sums the nodes on its path. A range add visits nodes from the root,
// defers right subranges on a stack, and reads then updates each node it fully covers.
// req is ready only between items; a held rsp beat stalls only a query at its end.
module range_add_point_query_tree #(
  parameter int MAX_ENTRIES = 1024,
  parameter int NODE_COUNT  = 4096,
  parameter int VALUE_WIDTH = 32
) (
  input wire logic clk,
  input wire logic rst,
  rapqt_req_if.sink   req,
  rapqt_rsp_if.source rsp,
  rapqt_cfg_if.sink   cfg
);
  import rapqt_pkg::*;

  // Position width: wide enough for the size register and for MAX_ENTRIES.
  localparam int CW_ENT = $clog2(MAX_ENTRIES + 1);
  localparam int CW     = (CW_ENT > SIZE_W) ? CW_ENT : SIZE_W;
  // Node address width, and node number width that holds one child past it.
  localparam int AW     = $clog2(NODE_COUNT);
  localparam int VW     = AW + 1;
  // Pending right subranges: at most one per tree level.
  localparam int SDEPTH = $clog2(MAX_ENTRIES) + 1;
  localparam int SIW    = $clog2(SDEPTH);
  localparam int SPW    = $clog2(SDEPTH + 1);

  state_t state, state_next;

  logic [SIZE_W-1:0] size_in_use;

  // Current frame: node, node span [tl, tr], and target range [lo, hi].
  // For loads and queries lo holds the leaf position.
  logic [VW-1:0]          v, v_next;
  logic [CW-1:0]          tl, tl_next, tr, tr_next, lo, lo_next, hi, hi_next;
  logic                   vbad, vbad_next;
  logic [VALUE_WIDTH-1:0] opv, opv_next;
  logic [VALUE_WIDTH-1:0] acc, acc_next;
  logic                   err, err_next;
  logic                   is_query, is_query_next;
  logic                   rd_pend, rd_pend_next;
  logic [AW-1:0]          clr_addr;

  // Stack of deferred right subranges for a range add.
  logic [VW-1:0] stk_v  [SDEPTH];
  logic [CW-1:0] stk_tl [SDEPTH];
  logic [CW-1:0] stk_tr [SDEPTH];
  logic [CW-1:0] stk_lo [SDEPTH];
  logic [CW-1:0] stk_hi [SDEPTH];
  logic [SPW-1:0] sp, sp_next;
  logic           push;

  // Output holding register.
  logic                          out_full;
  logic signed [RESULT_W-1:0]    out_value;
  logic                          out_err;
  logic                          out_load;

  // Node memory port.
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_wdata, mem_rdata;

  // Shared arithmetic.
  logic [CW-1:0]          n_act;
  logic [CW:0]            span_sum;
  logic [CW-1:0]          tm, tm1;
  logic [VW-1:0]          v_left, v_right;
  logic                   node_ok, at_leaf, go_left, go_right;
  logic [VALUE_WIDTH-1:0] add_a, add_sum;
  logic [SPW-1:0]         sp_m1;
  logic [SIW-1:0]         top_idx, push_idx;
  logic                   accept, slot_free;
  logic [CW-1:0]          first_c, last_c;
  logic [63:0]            op_wide, acc_wide;

  assign accept    = req.valid && req.ready;
  assign slot_free = !out_full || rsp.ready;
  assign cfg.ready = 1'b1;

  // Effective size: zero acts as one, anything above MAX_ENTRIES is clamped.
  always_comb begin
    priority if (size_in_use == '0) begin
      n_act = CW'(1);
    end else if (CW'(size_in_use) > CW'(MAX_ENTRIES)) begin
      n_act = CW'(MAX_ENTRIES);
    end else begin
      n_act = CW'(size_in_use);
    end
  end

  assign first_c  = CW'(req.first_index);
  assign last_c   = CW'(req.last_index);
  assign op_wide  = {{(64 - OPERAND_W){req.operand_value[OPERAND_W-1]}}, req.operand_value};
  assign acc_wide = 64'(acc);

  assign span_sum = {1'b0, tl} + {1'b0, tr};
  assign tm       = span_sum[CW:1];
  assign tm1      = tm + CW'(1);
  assign v_left   = {v[VW-2:0], 1'b0};
  assign v_right  = {v[VW-2:0], 1'b1};
  assign node_ok  = !vbad && (v < VW'(NODE_COUNT));
  assign at_leaf  = (tl == tr);
  assign go_left  = (lo <= tm);
  assign go_right = (hi > tm);

  // The one adder: path sum for queries, node plus delta for range adds.
  assign add_a   = (state == ST_AUPD) ? opv : acc;
  assign add_sum = add_a + mem_rdata;

  assign sp_m1    = sp - SPW'(1);
  assign top_idx  = sp_m1[SIW-1:0];
  assign push_idx = sp[SIW-1:0];

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(NODE_COUNT - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (req.req_type)
            REQ_LOAD: begin
              if (first_c < n_act) begin
                state_next = ST_WALK;
              end
            end
            REQ_ADD: begin
              if (first_c <= last_c && last_c < n_act) begin
                state_next = ST_AVISIT;
              end
            end
            REQ_QUERY: begin
              state_next = (first_c < n_act) ? ST_WALK : ST_QOUT;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_WALK: begin
        if (at_leaf) begin
          state_next = is_query ? ST_QTAIL : ST_IDLE;
        end
      end
      ST_QTAIL: state_next = ST_QOUT;
      ST_QOUT: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_AVISIT: begin
        if (!node_ok) begin
          if (sp == '0) begin
            state_next = ST_IDLE;
          end
        end else if (tl == lo && tr == hi) begin
          state_next = ST_AUPD;
        end
      end
      ST_AUPD: begin
        state_next = (sp == '0) ? ST_IDLE : ST_AVISIT;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Datapath, memory port and handshake controls.
  always_comb begin
    v_next        = v;
    tl_next       = tl;
    tr_next       = tr;
    lo_next       = lo;
    hi_next       = hi;
    vbad_next     = vbad;
    opv_next      = opv;
    acc_next      = acc;
    err_next      = err;
    is_query_next = is_query;
    rd_pend_next  = 1'b0;
    sp_next       = sp;
    push          = 1'b0;
    out_load      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = v[AW-1:0];
    mem_wdata     = opv;
    mem_raddr     = v[AW-1:0];
    req.ready     = (state == ST_IDLE);

    // A read issued last cycle lands in the path sum now.
    if (rd_pend) begin
      acc_next = add_sum;
    end

    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        if (accept) begin
          v_next        = VW'(1);
          tl_next       = '0;
          tr_next       = n_act - CW'(1);
          lo_next       = first_c;
          hi_next       = last_c;
          vbad_next     = 1'b0;
          opv_next      = op_wide[VALUE_WIDTH-1:0];
          acc_next      = '0;
          err_next      = !(first_c < n_act);
          is_query_next = (req.req_type == REQ_QUERY);
          sp_next       = '0;
        end
      end
      ST_WALK: begin
        if (is_query) begin
          rd_pend_next = node_ok;
        end else if (at_leaf && node_ok) begin
          mem_we = 1'b1;
        end
        if (!at_leaf) begin
          vbad_next = !node_ok;
          if (lo <= tm) begin
            v_next  = v_left;
            tr_next = tm;
          end else begin
            v_next  = v_right;
            tl_next = tm1;
          end
        end
      end
      ST_QTAIL: begin
      end
      ST_QOUT: begin
        out_load = slot_free;
      end
      ST_AVISIT: begin
        if (!node_ok) begin
          if (sp != '0) begin
            v_next  = stk_v[top_idx];
            tl_next = stk_tl[top_idx];
            tr_next = stk_tr[top_idx];
            lo_next = stk_lo[top_idx];
            hi_next = stk_hi[top_idx];
            sp_next = sp_m1;
          end
        end else if (tl == lo && tr == hi) begin
          // Canonical node: read it now, add the delta next cycle.
        end else if (go_left && go_right) begin
          push    = 1'b1;
          sp_next = sp + SPW'(1);
          v_next  = v_left;
          tr_next = tm;
          hi_next = tm;
        end else if (go_left) begin
          v_next  = v_left;
          tr_next = tm;
        end else begin
          v_next  = v_right;
          tl_next = tm1;
        end
      end
      ST_AUPD: begin
        mem_we    = 1'b1;
        mem_wdata = add_sum;
        if (sp != '0) begin
          v_next  = stk_v[top_idx];
          tl_next = stk_tl[top_idx];
          tr_next = stk_tr[top_idx];
          lo_next = stk_lo[top_idx];
          hi_next = stk_hi[top_idx];
          sp_next = sp_m1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      size_in_use <= SIZE_RESET;
      rd_pend     <= 1'b0;
      sp          <= '0;
      out_full    <= 1'b0;
    end else begin
      state    <= state_next;
      rd_pend  <= rd_pend_next;
      sp       <= sp_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cfg.valid && cfg.ready) begin
        size_in_use <= cfg.size_in_use;
      end
      if (out_load) begin
        out_full <= 1'b1;
      end else if (rsp.ready) begin
        out_full <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    v        <= v_next;
    tl       <= tl_next;
    tr       <= tr_next;
    lo       <= lo_next;
    hi       <= hi_next;
    vbad     <= vbad_next;
    opv      <= opv_next;
    acc      <= acc_next;
    err      <= err_next;
    is_query <= is_query_next;
    if (push) begin
      // The deferred right half starts at tm+1, so its left end is tm+1 too.
      stk_v[push_idx]  <= v_right;
      stk_tl[push_idx] <= tm1;
      stk_tr[push_idx] <= tr;
      stk_lo[push_idx] <= tm1;
      stk_hi[push_idx] <= hi;
    end
    if (out_load) begin
      out_value <= acc_wide[RESULT_W-1:0];
      out_err   <= err;
    end
  end

  assign rsp.valid       = out_full;
  assign rsp.point_value = out_value;
  assign rsp.index_error = out_err;

  rapqt_node_ram #(
    .DEPTH (NODE_COUNT),
    .WIDTH (VALUE_WIDTH)
  ) u_node_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire
